FILE: rtl/mpq_pkg.sv
// Shared types and constants for the minimum priority queue.
// No dependencies; used by mpq_min_scan and min_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned FIELD_W = 32;  // width of value ports
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  // running minimum and the slot it came from
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [IDX_W-1:0]              idx;
  } scan_t;

endpackage

`default_nettype wire

FILE: rtl/min_priority_queue.sv
// Top level of the minimum priority queue: entry memory, control FSM, result register.
// Depends on mpq_pkg and mpq_min_scan.
`timescale 1ns / 1ps
`default_nettype none

// Minimum priority queue of up to 16 signed 32-bit entries, one result per transaction.
// Entries sit in a single-port-write, registered-read memory in no particular order.
// Insert, a rejected insert, remove/peek on an empty queue and the unused code go
// from accept straight to the result. Remove and peek on a non-empty queue read the
// memory one entry a cycle while a running compare tracks the minimum; on remove
// the last entry is written into the hole of the removed one, so nothing shifts.
// A new transaction is taken as soon as the result is parked in the output register,
// so a stalled consumer holds back at most one further transaction.
module min_priority_queue (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [mpq_pkg::OP_W-1:0]               operation_i,
  input  wire logic signed [mpq_pkg::FIELD_W-1:0]     value_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [mpq_pkg::FIELD_W-1:0]          min_value_o,
  output logic [mpq_pkg::STAT_W-1:0]                  status_o,
  output logic [mpq_pkg::OCC_W-1:0]                   occupancy_o
);

  localparam int unsigned VW = mpq_pkg::VALUE_WIDTH;

  // entry memory
  logic signed [VW-1:0] mem_q [mpq_pkg::DEPTH];
  logic                 mem_we;
  logic [mpq_pkg::IDX_W-1:0] mem_waddr;
  logic signed [VW-1:0] mem_wdata;
  logic                 rd_en;
  logic signed [VW-1:0] rdata_q;

  mpq_pkg::state_e state_q, state_d;

  logic [mpq_pkg::CNT_W-1:0] count_q, count_d;
  logic [mpq_pkg::CNT_W-1:0] issue_q, issue_d;
  logic                      rvalid_q;
  logic [mpq_pkg::IDX_W-1:0] raddr_q;
  logic                      remove_q, remove_d;

  // pending result
  logic signed [VW-1:0]      res_min_q, res_min_d;
  mpq_pkg::status_e          res_stat_q, res_stat_d;

  // output register
  logic                      out_valid_q;
  logic signed [mpq_pkg::FIELD_W-1:0] out_min_q;
  logic [mpq_pkg::STAT_W-1:0] out_stat_q;
  logic [mpq_pkg::OCC_W-1:0]  out_occ_q;

  logic         in_acc;
  logic         out_free;
  logic         scan_start;
  logic         scan_last;
  mpq_pkg::op_e op;
  mpq_pkg::scan_t scan_min;

  assign op         = mpq_pkg::op_e'(operation_i);
  assign in_stall_o = (state_q != mpq_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign scan_start = in_acc && (op == mpq_pkg::OP_REMOVE || op == mpq_pkg::OP_PEEK)
                      && (count_q != '0);
  assign rd_en      = (state_q == mpq_pkg::S_SCAN) && (issue_q < count_q);
  assign scan_last  = (state_q == mpq_pkg::S_SCAN) && rvalid_q
                      && (mpq_pkg::CNT_W'(raddr_q) == count_q - 1'b1);

  mpq_min_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (scan_start),
    .data_valid_i (rvalid_q),
    .data_i       (rdata_q),
    .data_idx_i   (raddr_q),
    .min_o        (scan_min)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpq_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = scan_start ? mpq_pkg::S_SCAN : mpq_pkg::S_RESP;
        end
      end
      mpq_pkg::S_SCAN: begin
        if (scan_last) begin
          state_d = mpq_pkg::S_RESP;
        end
      end
      mpq_pkg::S_RESP: begin
        if (out_free) begin
          state_d = mpq_pkg::S_IDLE;
        end
      end
      default: state_d = mpq_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    count_d    = count_q;
    issue_d    = issue_q;
    remove_d   = remove_q;
    res_min_d  = res_min_q;
    res_stat_d = res_stat_q;
    mem_we     = 1'b0;
    mem_waddr  = count_q[mpq_pkg::IDX_W-1:0];
    mem_wdata  = VW'(value_i);
    case (state_q)
      mpq_pkg::S_IDLE: begin
        if (in_acc) begin
          res_min_d  = '0;
          res_stat_d = mpq_pkg::STAT_OK;
          issue_d    = '0;
          remove_d   = (op == mpq_pkg::OP_REMOVE);
          case (op)
            mpq_pkg::OP_INSERT: begin
              if (count_q >= mpq_pkg::CNT_W'(mpq_pkg::DEPTH)) begin
                res_stat_d = mpq_pkg::STAT_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            mpq_pkg::OP_REMOVE, mpq_pkg::OP_PEEK: begin
              if (count_q == '0) begin
                res_stat_d = mpq_pkg::STAT_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      mpq_pkg::S_SCAN: begin
        if (rd_en) begin
          issue_d = issue_q + 1'b1;
        end
        if (scan_last) begin
          res_min_d = scan_min.value;
          if (remove_q) begin
            // move the last entry into the removed slot
            mem_we    = 1'b1;
            mem_waddr = scan_min.idx;
            mem_wdata = rdata_q;
            count_d   = count_q - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[issue_q[mpq_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpq_pkg::S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      rvalid_q    <= 1'b0;
      remove_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      issue_q  <= issue_d;
      rvalid_q <= rd_en;
      remove_q <= remove_d;
      if (state_q == mpq_pkg::S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q    <= issue_q[mpq_pkg::IDX_W-1:0];
    res_min_q  <= res_min_d;
    res_stat_q <= res_stat_d;
    if (state_q == mpq_pkg::S_RESP && out_free) begin
      out_min_q  <= mpq_pkg::FIELD_W'(res_min_q);
      out_stat_q <= res_stat_q;
      out_occ_q  <= mpq_pkg::OCC_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_value_o = out_min_q;
  assign status_o    = out_stat_q;
  assign occupancy_o = out_occ_q;

  // count never runs past the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mpq_pkg::CNT_W'(mpq_pkg::DEPTH))
    else $error("entry count exceeds depth");

  // a scan only starts on a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpq_pkg::S_IDLE && state_d == mpq_pkg::S_SCAN) |-> (count_q != '0))
    else $error("scan started on empty queue");

  // the hole fill on remove shrinks the queue by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpq_pkg::S_SCAN && mem_we) |=> (count_q == $past(count_q) - 1'b1))
    else $error("remove write without count decrement");

  // a fresh result reports the current fill level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (out_occ_q == mpq_pkg::OCC_W'(count_q)))
    else $error("reported occupancy mismatch");

endmodule

`default_nettype wire

FILE: rtl/mpq_min_scan.sv
// Running-minimum tracker fed by the entry memory read stream.
// Depends on mpq_pkg for widths and the scan_t result type.
`timescale 1ns / 1ps
`default_nettype none

module mpq_min_scan (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      start_i,
  input  wire logic                                      data_valid_i,
  input  wire logic signed [mpq_pkg::VALUE_WIDTH-1:0]    data_i,
  input  wire logic [mpq_pkg::IDX_W-1:0]                 data_idx_i,
  output mpq_pkg::scan_t                                 min_o
);

  mpq_pkg::scan_t best_q, best_d;
  logic           have_q, have_d;

  // min_o already includes the beat on data_i; strict < keeps the earliest of equal minima
  always_comb begin
    best_d = best_q;
    have_d = have_q;
    if (data_valid_i) begin
      have_d = 1'b1;
      if (!have_q || (data_i < best_q.value)) begin
        best_d.value = data_i;
        best_d.idx   = data_idx_i;
      end
    end
    if (start_i) begin
      have_d = 1'b0;
    end
  end

  assign min_o = best_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

endmodule

`default_nettype wire

FILE: bench/min_priority_queue_test.sv
// Self-checking bench for min_priority_queue: directed corner cases, then random op mixes.
// A class keeps a copy of the held entries and checks each result. Depends on mpq_pkg and min_priority_queue.
`timescale 1ns / 1ps

module min_priority_queue_test;

  localparam logic [mpq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [mpq_pkg::FIELD_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [mpq_pkg::FIELD_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [mpq_pkg::FIELD_W-1:0] min_value;
    mpq_pkg::status_e                   status;
    logic [mpq_pkg::OCC_W-1:0]          occupancy;
  } queue_result_t;

  // Tracks the held entries and the results still owed by the queue.
  class min_queue_tracker;
    logic signed [mpq_pkg::FIELD_W-1:0] held[$];
    queue_result_t awaited[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int pending_count();
      return awaited.size();
    endfunction

    function void note_operation(logic [mpq_pkg::OP_W-1:0] op,
                                 logic signed [mpq_pkg::FIELD_W-1:0] value);
      queue_result_t res;
      int pos;
      res.min_value = '0;
      res.status    = mpq_pkg::STAT_OK;
      pos = 0;
      case (op)
        mpq_pkg::OP_INSERT: begin
          if (held.size() >= int'(mpq_pkg::DEPTH)) res.status = mpq_pkg::STAT_FULL;
          else held = {held, value};
        end
        mpq_pkg::OP_REMOVE, mpq_pkg::OP_PEEK: begin
          if (held.size() == 0) begin
            res.status = mpq_pkg::STAT_EMPTY;
          end else begin
            // first occurrence of the minimum
            for (int i = 1; i < held.size(); i++)
              if (held[i] < held[pos]) pos = i;
            res.min_value = held[pos];
            if (op == mpq_pkg::OP_REMOVE) held.delete(pos);
          end
        end
        default: ;
      endcase
      res.occupancy = mpq_pkg::OCC_W'(held.size());
      awaited = {awaited, res};
    endfunction

    function void check_result(logic signed [mpq_pkg::FIELD_W-1:0] min_value,
                               logic [mpq_pkg::STAT_W-1:0] status,
                               logic [mpq_pkg::OCC_W-1:0] occupancy);
      queue_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected transaction min_value %0d status %0d occupancy %0d",
                 $time, min_value, status, occupancy);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (min_value !== want.min_value) begin
        $display("%0t: min_value expected %0d got %0d", $time, want.min_value, min_value);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, status);
        errors++;
      end
      if (occupancy !== want.occupancy) begin
        $display("%0t: occupancy expected %0d got %0d", $time, want.occupancy, occupancy);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [mpq_pkg::OP_W-1:0] operation_i;
  logic signed [mpq_pkg::FIELD_W-1:0] value_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [mpq_pkg::FIELD_W-1:0] min_value_o;
  logic [mpq_pkg::STAT_W-1:0] status_o;
  logic [mpq_pkg::OCC_W-1:0] occupancy_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  min_queue_tracker tracker = new();

  min_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .min_value_o (min_value_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result(min_value_o, status_o, occupancy_o);
  end

  // Offers one transaction and returns at the edge that accepts it.
  task automatic push_op(input logic [mpq_pkg::OP_W-1:0] op,
                         input logic signed [mpq_pkg::FIELD_W-1:0] value);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i  <= 1'b0;
      operation_i <= mpq_pkg::OP_W'($urandom);
      value_i     <= $urandom;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_operation(op, value);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending_count() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [mpq_pkg::FIELD_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2:       return '0;
      3:       return -1;
      4, 5:    return $signed(mpq_pkg::FIELD_W'($urandom_range(15))) - 8;  // dense, many ties
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [mpq_pkg::OP_W-1:0] pick_op(int unsigned insert_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < insert_pct) return mpq_pkg::OP_INSERT;
    r = $urandom_range(19);
    if (r == 0) return OP_UNUSED;
    if (r < 13) return mpq_pkg::OP_REMOVE;
    return mpq_pkg::OP_PEEK;
  endfunction

  initial begin
    int unsigned insert_pct;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = mpq_pkg::OP_INSERT;
    value_i     = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty queue, unused code, extremes, ties
    push_op(mpq_pkg::OP_REMOVE, 32'sd5);
    push_op(mpq_pkg::OP_PEEK, -1);
    push_op(OP_UNUSED, INT_MAX);
    push_op(mpq_pkg::OP_INSERT, INT_MAX);
    push_op(mpq_pkg::OP_INSERT, INT_MIN);
    push_op(mpq_pkg::OP_INSERT, '0);
    push_op(mpq_pkg::OP_INSERT, -1);
    push_op(mpq_pkg::OP_INSERT, INT_MIN);
    push_op(mpq_pkg::OP_PEEK, '0);
    push_op(mpq_pkg::OP_REMOVE, '0);
    push_op(mpq_pkg::OP_REMOVE, '0);
    push_op(OP_UNUSED, INT_MIN);
    // fill up, then one insert too many
    for (int i = 0; i < 13; i++)
      push_op(mpq_pkg::OP_INSERT, (i % 3 == 0) ? INT_MAX : $signed(i - 6));
    push_op(mpq_pkg::OP_INSERT, 32'sd1);
    push_op(mpq_pkg::OP_PEEK, '0);

    for (int phase = 0; phase < 20; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      for (int n = 0; n < 95; n++) begin
        if (n % 30 == 0) begin
          case ($urandom_range(2))
            0:       insert_pct = 80;
            1:       insert_pct = 50;
            default: insert_pct = 25;
          endcase
        end
        push_op(pick_op(insert_pct), pick_value());
      end
    end

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/mpq_pkg.sv
rtl/mpq_min_scan.sv
rtl/min_priority_queue.sv
bench/min_priority_queue_test.sv
